FILE: rtl/ffpa_pkg.sv
// ffpa_pkg: shared widths, codes and controller/datapath signal bundles
// for the first-fit page run allocator. No dependencies.

package ffpa_pkg;

    localparam int ADDR_W    = 29;
    localparam int COUNT_W   = 18;
    localparam int WORD_BITS = 32;
    localparam int WORD_SH   = 5;

    localparam int DEF_FRAME_COUNT     = 131072;
    localparam int DEF_RESERVED_FRAMES = 1133;
    localparam int DEF_PAGE_BYTES      = 4096;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef struct packed {
        logic load;
        logic init_wr;
        logic scan_init;
        logic rd;
        logic flush;
        logic scan_eval;
        logic mark_begin;
        logic mark_wr;
        logic resp_load;
    } t_cmd;

    typedef struct packed {
        logic init_last;
        logic is_alloc;
        logic skip;
        logic addr_end;
        logic hit;
        logic scan_miss;
        logic mark_more;
        logic p1_busy;
        logic out_busy;
    } t_sts;

endpackage

FILE: rtl/ffpa_req_if.sv
// ffpa_req_if: request channel (valid/ready plus request payload)
// depends on ffpa_pkg for field widths

interface ffpa_req_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [ffpa_pkg::COUNT_W-1:0]  page_count;
    logic [ffpa_pkg::ADDR_W-1:0]   free_address;

    modport source (output valid, output action, output page_count, output free_address,
                    input ready);
    modport sink   (input valid, input action, input page_count, input free_address,
                    output ready);
endinterface

FILE: rtl/ffpa_rsp_if.sv
// ffpa_rsp_if: result channel (valid/ready plus result payload)
// depends on ffpa_pkg for field widths

interface ffpa_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        granted;
    logic [ffpa_pkg::ADDR_W-1:0] run_address;

    modport source (output valid, output granted, output run_address, input ready);
    modport sink   (input valid, input granted, input run_address, output ready);
endinterface

FILE: rtl/ffpa_ctrl.sv
// ffpa_ctrl: sequencing state machine of the allocator
// depends on ffpa_pkg (t_cmd, t_sts)

module ffpa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  ffpa_pkg::t_sts   i_sts,
    output ffpa_pkg::t_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DISP,
        S_SCAN,
        S_MSET,
        S_MARK,
        S_RESP
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.init_wr = 1'b1;
                if (i_sts.init_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                o_cmd.flush = 1'b1;
                if (i_sts.skip) begin
                    n_state = S_RESP;
                end else if (i_sts.is_alloc) begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end else begin
                    n_state = S_MSET;
                end
            end
            S_SCAN: begin
                o_cmd.scan_eval = 1'b1;
                if (i_sts.hit) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_MSET;
                end else if (i_sts.scan_miss) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_RESP;
                end else begin
                    o_cmd.rd = !i_sts.addr_end;
                end
            end
            S_MSET: begin
                o_cmd.mark_begin = 1'b1;
                n_state          = S_MARK;
            end
            S_MARK: begin
                o_cmd.mark_wr = 1'b1;
                o_cmd.rd      = i_sts.mark_more;
                if (!i_sts.mark_more && !i_sts.p1_busy) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (!i_sts.out_busy) begin
                    o_cmd.resp_load = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/ffpa_dp.sv
// ffpa_dp: frame map memory, scan pipeline, run tracking, mark engine, result register
// depends on ffpa_pkg (widths, codes, t_cmd, t_sts)

module ffpa_dp #(
    parameter int FRAME_COUNT     = ffpa_pkg::DEF_FRAME_COUNT,
    parameter int RESERVED_FRAMES = ffpa_pkg::DEF_RESERVED_FRAMES,
    parameter int PAGE_BYTES      = ffpa_pkg::DEF_PAGE_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ffpa_pkg::t_cmd                i_cmd,
    output ffpa_pkg::t_sts                o_sts,
    input  logic                          i_action,
    input  logic [ffpa_pkg::COUNT_W-1:0]  i_page_count,
    input  logic [ffpa_pkg::ADDR_W-1:0]   i_free_address,
    output logic                          o_rsp_valid,
    input  logic                          i_rsp_ready,
    output logic                          o_granted,
    output logic [ffpa_pkg::ADDR_W-1:0]   o_run_address
);

    localparam int WB     = ffpa_pkg::WORD_BITS;
    localparam int WS     = ffpa_pkg::WORD_SH;
    localparam int CW     = ffpa_pkg::COUNT_W;
    localparam int AW     = ffpa_pkg::ADDR_W;
    localparam int NWORDS = (FRAME_COUNT + WB - 1) / WB;
    localparam int WA     = $clog2(NWORDS);
    localparam int FW     = WA + WS;
    localparam int RW     = FW + 1;
    localparam int SUM_W  = ((RW > CW) ? RW : CW) + 1;
    localparam int EXT_W  = AW + 1;
    localparam int PB_SH  = $clog2(PAGE_BYTES);
    localparam int FA_W   = AW - PB_SH;
    localparam int TW     = WS + 1;

    // control registers
    logic [WA:0]        r_addr;
    logic               r_p1_vld;
    logic               r_p2_vld;
    logic               r_hit;
    logic               r_out_vld;

    // request and working registers
    logic               r_action;
    logic [CW-1:0]      r_count;
    logic [EXT_W-1:0]   r_first;
    logic [RW-1:0]      r_run;
    logic [FW-1:0]      r_start;
    logic [FW-1:0]      r_lo;
    logic [FW-1:0]      r_hi;

    // map memory
    logic [WB-1:0]      r_mem [NWORDS];
    logic [WB-1:0]      r_mem_q;
    logic [WA-1:0]      r_p1_idx;

    // scan stage two
    logic [WA-1:0]      r_p2_idx;
    logic [TW-1:0]      r_p2_tz;
    logic [TW-1:0]      r_p2_top;
    logic               r_p2_all;
    logic [WB-1:0]      r_p2_fm;

    logic               r_out_granted;
    logic [AW-1:0]      r_out_addr;

    logic               is_alloc;
    logic               skip;
    logic [EXT_W-1:0]   count_ext;

    logic [TW-1:0]      tz;
    logic [TW-1:0]      top;
    logic [WB-1:0]      fm;
    logic [WB-1:0]      g [WS];
    logic [WB-1:0]      acc;
    logic [WS-1:0]      c_lo;

    logic               prev_ok;
    logic               fold_any;
    logic [WS-1:0]      fold_pos;
    logic [FW-1:0]      hit_start;
    logic [FW-1:0]      base;

    logic [FW-1:0]      lo_next;
    logic [FW-1:0]      hi_next;
    logic [SUM_W-1:0]   alloc_end;
    logic [EXT_W-1:0]   free_end;

    logic [WB-1:0]      init_word;
    logic [EXT_W-1:0]   init_frame;
    logic [WB-1:0]      mask;
    logic [WB-1:0]      mark_word;
    logic [WS-1:0]      lo_b;
    logic [WS-1:0]      hi_b;
    logic [FW+PB_SH-1:0] addr_wide;

    assign is_alloc  = (r_action == ffpa_pkg::ACT_ALLOC);
    assign count_ext = EXT_W'(r_count);

    always_comb begin
        if (is_alloc) begin
            skip = (r_count == '0) || (count_ext > EXT_W'(FRAME_COUNT));
        end else begin
            skip = (r_count == '0) || (r_first >= EXT_W'(FRAME_COUNT));
        end
    end

    // stage two: free-run encoders and window fold of the word just read
    always_comb begin
        tz  = TW'(WB);
        top = TW'(WB);
        for (int j = WB - 1; j >= 0; j--) begin
            if (r_mem_q[j]) begin
                tz = TW'(j);
            end
        end
        for (int j = 0; j < WB; j++) begin
            if (r_mem_q[j]) begin
                top = TW'(WB - 1 - j);
            end
        end
    end

    always_comb begin
        g[0] = ~r_mem_q;
        for (int b = 1; b < WS; b++) begin
            g[b] = g[b-1] & (g[b-1] >> (1 << (b - 1)));
        end
        c_lo = r_count[WS-1:0];
        acc  = '1;
        for (int b = 0; b < WS; b++) begin
            if (c_lo[b]) begin
                acc = acc & (g[b] >> (c_lo & WS'((1 << b) - 1)));
            end
        end
        fm = (r_count[CW-1:WS] == '0) ? acc : '0;
    end

    // stage three: run decision
    always_comb begin
        prev_ok  = (SUM_W'(r_run) + SUM_W'(r_p2_tz)) >= SUM_W'(r_count);
        fold_any = |r_p2_fm;
        fold_pos = '0;
        for (int j = WB - 1; j >= 0; j--) begin
            if (r_p2_fm[j]) begin
                fold_pos = WS'(j);
            end
        end
        base = {r_p2_idx, {WS{1'b0}}};
        if (prev_ok) begin
            hit_start = base - FW'(r_run);
        end else begin
            hit_start = {r_p2_idx, fold_pos};
        end
    end

    // run bounds for the mark pass
    always_comb begin
        alloc_end = SUM_W'(r_start) + SUM_W'(r_count) - SUM_W'(1);
        free_end  = r_first + count_ext - EXT_W'(1);
        if (is_alloc) begin
            lo_next = r_start;
            hi_next = FW'(alloc_end);
        end else begin
            lo_next = FW'(r_first);
            if (free_end >= EXT_W'(FRAME_COUNT)) begin
                hi_next = FW'(FRAME_COUNT - 1);
            end else begin
                hi_next = FW'(free_end);
            end
        end
    end

    // reset image: reserved frames and padding past the map end are busy
    always_comb begin
        for (int j = 0; j < WB; j++) begin
            init_frame   = EXT_W'({r_addr[WA-1:0], WS'(j)});
            init_word[j] = (init_frame < EXT_W'(RESERVED_FRAMES)) ||
                           (init_frame >= EXT_W'(FRAME_COUNT));
        end
    end

    always_comb begin
        lo_b = (r_p1_idx == r_lo[FW-1:WS]) ? r_lo[WS-1:0] : '0;
        hi_b = (r_p1_idx == r_hi[FW-1:WS]) ? r_hi[WS-1:0] : WS'(WB - 1);
        mask = ({WB{1'b1}} << lo_b) & ({WB{1'b1}} >> (WS'(WB - 1) - hi_b));
        if (is_alloc) begin
            mark_word = r_mem_q | mask;
        end else begin
            mark_word = r_mem_q & ~mask;
        end
    end

    assign addr_wide = {r_start, {PB_SH{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr    <= '0;
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_hit     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.scan_init) begin
                r_addr <= '0;
            end else if (i_cmd.mark_begin) begin
                r_addr <= {1'b0, lo_next[FW-1:WS]};
            end else if (i_cmd.init_wr || i_cmd.rd) begin
                r_addr <= r_addr + 1'b1;
            end
            r_p1_vld <= i_cmd.rd && !i_cmd.flush;
            r_p2_vld <= r_p1_vld && !i_cmd.flush;
            if (i_cmd.load) begin
                r_hit <= 1'b0;
            end else if (i_cmd.scan_eval && o_sts.hit) begin
                r_hit <= 1'b1;
            end
            if (i_cmd.resp_load) begin
                r_out_vld <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_count  <= i_page_count;
            r_first  <= EXT_W'(i_free_address[AW-1:AW-FA_W]);
        end
        if (i_cmd.scan_init) begin
            r_run <= '0;
        end else if (i_cmd.scan_eval && r_p2_vld) begin
            if (r_p2_all) begin
                r_run <= r_run + RW'(WB);
            end else begin
                r_run <= RW'(r_p2_top);
            end
        end
        if (i_cmd.scan_eval && o_sts.hit) begin
            r_start <= hit_start;
        end
        if (i_cmd.mark_begin) begin
            r_lo <= lo_next;
            r_hi <= hi_next;
        end
        if (i_cmd.rd) begin
            r_mem_q  <= r_mem[r_addr[WA-1:0]];
            r_p1_idx <= r_addr[WA-1:0];
        end
        if (i_cmd.init_wr) begin
            r_mem[r_addr[WA-1:0]] <= init_word;
        end else if (i_cmd.mark_wr && r_p1_vld) begin
            r_mem[r_p1_idx] <= mark_word;
        end
        r_p2_idx <= r_p1_idx;
        r_p2_tz  <= tz;
        r_p2_top <= top;
        r_p2_all <= (r_mem_q == '0);
        r_p2_fm  <= fm;
        if (i_cmd.resp_load) begin
            r_out_granted <= !is_alloc || r_hit;
            r_out_addr    <= r_hit ? AW'(addr_wide) : '0;
        end
    end

    always_comb begin
        o_sts.init_last = (r_addr == (WA + 1)'(NWORDS - 1));
        o_sts.is_alloc  = is_alloc;
        o_sts.skip      = skip;
        o_sts.addr_end  = (r_addr == (WA + 1)'(NWORDS));
        o_sts.hit       = r_p2_vld && (prev_ok || fold_any);
        o_sts.scan_miss = r_p2_vld && !(prev_ok || fold_any) &&
                          (r_p2_idx == WA'(NWORDS - 1));
        o_sts.mark_more = (r_addr <= {1'b0, r_hi[FW-1:WS]});
        o_sts.p1_busy   = r_p1_vld;
        o_sts.out_busy  = r_out_vld && !i_rsp_ready;
    end

    assign o_rsp_valid   = r_out_vld;
    assign o_granted     = r_out_granted;
    assign o_run_address = r_out_addr;

endmodule

FILE: rtl/first_fit_page_run_allocator_top.sv
// first_fit_page_run_allocator_top: top level, joins controller and datapath
// depends on ffpa_pkg, ffpa_req_if, ffpa_rsp_if, ffpa_ctrl, ffpa_dp

// One request is handled at a time. After reset a clearing pass writes the frame map,
// one 32-frame word per cycle, and no request is taken until it ends. An allocate
// reads the map one word per cycle through a three-stage pipe and stops at the first
// fitting run; it then marks the run with a read-modify-write pass of one word per
// cycle and loads the result once the output register is free. With no fitting run
// the scan ends at the last map word and a failed result is loaded. A free clears the
// words it touches in the same read-modify-write pass; a zero count or a bad range
// skips the scan and the mark pass. The map sits in one memory with a read and a write
// port, which sets the 32-frames-per-cycle scan rate. A result waits in an output
// register while the next request is taken. PAGE_BYTES must be a power of two.

module first_fit_page_run_allocator_top #(
    parameter int FRAME_COUNT     = ffpa_pkg::DEF_FRAME_COUNT,
    parameter int RESERVED_FRAMES = ffpa_pkg::DEF_RESERVED_FRAMES,
    parameter int PAGE_BYTES      = ffpa_pkg::DEF_PAGE_BYTES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ffpa_req_if.sink      i_req,
    ffpa_rsp_if.source    o_rsp
);

    ffpa_pkg::t_cmd cmd;
    ffpa_pkg::t_sts sts;
    logic           req_ready;

    assign i_req.ready = req_ready;

    ffpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ffpa_dp #(
        .FRAME_COUNT     (FRAME_COUNT),
        .RESERVED_FRAMES (RESERVED_FRAMES),
        .PAGE_BYTES      (PAGE_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_action       (i_req.action),
        .i_page_count   (i_req.page_count),
        .i_free_address (i_req.free_address),
        .o_rsp_valid    (o_rsp.valid),
        .i_rsp_ready    (o_rsp.ready),
        .o_granted      (o_rsp.granted),
        .o_run_address  (o_rsp.run_address)
    );

    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.granted |-> o_rsp.run_address == '0)
        else $error("failed request carries a nonzero address");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("request taken while another is in work");

    a_flush_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.flush |-> !cmd.rd)
        else $error("map read issued during pipe flush");

    a_result_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.resp_load |=> o_rsp.valid)
        else $error("loaded result not presented");

endmodule
